/* src/linear_adrc_controller_macros.svh */
// ----------------------------------------------------------------------------
// linear_adrc_controller assertion macros
// same-cycle and next-cycle implication checks, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADRC_CONTROLLER_MACROS_SVH
`define LINEAR_ADRC_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define LADRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ladrc check failed");
`define LADRC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ladrc check failed");
`else
`define LADRC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LADRC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/ladrc_pkg.sv */
// ----------------------------------------------------------------------------
// ladrc_pkg
// shared types, constants and the microcode program of the adrc controller
// ----------------------------------------------------------------------------
package ladrc_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS     = 20;
  localparam int PROD_FULL_W   = 2 * DATA_W + 1;
  localparam int PROD_W        = PROD_FULL_W - FRAC_BITS;
  localparam int ACC_W         = 48;
  localparam int STEP_W        = 5;
  localparam int NUM_STEPS     = 26;
  localparam int CFG_IDX_W     = 3;
  localparam int STEP_SHIFT_DEF = 10;

  localparam logic [DATA_W-1:0] RST_SETPOINT = 32'd1048576;
  localparam logic [DATA_W-1:0] RST_B0       = 32'd1048576;
  localparam logic [DATA_W-1:0] RST_RCP      = 32'd1048576;
  localparam logic [DATA_W-1:0] RST_B1       = 32'd31457280;
  localparam logic [DATA_W-1:0] RST_B2       = 32'd314572800;
  localparam logic [DATA_W-1:0] RST_B3       = 32'd1048576000;
  localparam logic [DATA_W-1:0] RST_KP       = 32'd26214400;
  localparam logic [DATA_W-1:0] RST_KD       = 32'd10485760;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT, REG_CONTROL_GAIN, REG_CONTROL_GAIN_RECIP, REG_OBS_GAIN_ONE,
    REG_OBS_GAIN_TWO, REG_OBS_GAIN_THREE, REG_PROP_GAIN, REG_DERIV_GAIN
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0]        b0;
    logic [DATA_W-1:0]        rcp;
    logic [DATA_W-1:0]        b1;
    logic [DATA_W-1:0]        b2;
    logic [DATA_W-1:0]        b3;
    logic [DATA_W-1:0]        kp;
    logic [DATA_W-1:0]        kd;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] disturb;
    logic                     sat;
  } res_t;

  typedef enum logic [1:0] {FLOW_RUN, FLOW_WAIT_IN, FLOW_WAIT_OUT} flow_t;
  typedef enum logic [1:0] {MA_E0, MA_UP, MA_T} mul_a_t;
  typedef enum logic [2:0] {G_B0, G_RCP, G_B1, G_B2, G_B3, G_KP, G_KD} gain_t;
  typedef enum logic [1:0] {BASE_ACC, BASE_X, BASE_ZERO} base_t;
  typedef enum logic [2:0] {
    TERM_NONE, TERM_ADD_P, TERM_SUB_P, TERM_SUB_X, TERM_ADD_TSH
  } term_t;
  typedef enum logic [2:0] {X_Z1, X_Z2, X_Z3, X_Y, X_SP} xsel_t;
  typedef enum logic [2:0] {
    DST_NONE, DST_E0, DST_T, DST_Z1, DST_Z2, DST_Z3, DST_UP
  } dst_t;

  typedef struct packed {
    flow_t             flow;
    logic              jmp;
    logic [STEP_W-1:0] target;
    logic              mul_en;
    mul_a_t            mul_a;
    gain_t             gain;
    base_t             base;
    term_t             term;
    xsel_t             xsel;
    dst_t              dst;
    logic              clr;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{
    flow: FLOW_RUN, jmp: 1'b0, target: '0, mul_en: 1'b0, mul_a: MA_E0,
    gain: G_B0, base: BASE_ACC, term: TERM_NONE, xsel: X_Z1, dst: DST_NONE,
    clr: 1'b0
  };

  // one control word per step
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = UCW_NOP;
    case (step)
      STEP_W'(0): begin
        w.flow = FLOW_WAIT_IN; w.clr = 1'b1; w.base = BASE_X; w.xsel = X_Z1;
      end
      STEP_W'(1): begin
        w.term = TERM_SUB_X; w.xsel = X_Y;
      end
      STEP_W'(2): begin
        w.dst = DST_E0;
      end
      STEP_W'(3): begin
        w.mul_en = 1'b1; w.mul_a = MA_E0; w.gain = G_B1;
      end
      STEP_W'(4): begin
        w.base = BASE_X; w.xsel = X_Z2; w.term = TERM_SUB_P;
        w.mul_en = 1'b1; w.mul_a = MA_E0; w.gain = G_B2;
      end
      STEP_W'(5): begin
        w.dst = DST_T;
      end
      STEP_W'(6): begin
        w.base = BASE_X; w.xsel = X_Z1; w.term = TERM_ADD_TSH;
      end
      STEP_W'(7): begin
        w.dst = DST_Z1; w.base = BASE_X; w.xsel = X_Z3; w.term = TERM_SUB_P;
        w.mul_en = 1'b1; w.mul_a = MA_UP; w.gain = G_B0;
      end
      STEP_W'(8): begin
        w.term = TERM_ADD_P; w.mul_en = 1'b1; w.mul_a = MA_E0; w.gain = G_B3;
      end
      STEP_W'(9): begin
        w.dst = DST_T;
      end
      STEP_W'(10): begin
        w.base = BASE_X; w.xsel = X_Z2; w.term = TERM_ADD_TSH;
      end
      STEP_W'(11): begin
        w.dst = DST_Z2; w.base = BASE_ZERO; w.term = TERM_SUB_P;
      end
      STEP_W'(12): begin
        w.dst = DST_T;
      end
      STEP_W'(13): begin
        w.base = BASE_X; w.xsel = X_Z3; w.term = TERM_ADD_TSH;
      end
      STEP_W'(14): begin
        w.dst = DST_Z3; w.base = BASE_X; w.xsel = X_SP;
      end
      STEP_W'(15): begin
        w.term = TERM_SUB_X; w.xsel = X_Z1;
      end
      STEP_W'(16): begin
        w.dst = DST_T;
      end
      STEP_W'(17): begin
        w.mul_en = 1'b1; w.mul_a = MA_T; w.gain = G_KP;
        w.base = BASE_ZERO; w.term = TERM_SUB_X; w.xsel = X_Z2;
      end
      STEP_W'(18): begin
        w.dst = DST_T; w.base = BASE_ZERO; w.term = TERM_ADD_P;
      end
      STEP_W'(19): begin
        w.mul_en = 1'b1; w.mul_a = MA_T; w.gain = G_KD;
      end
      STEP_W'(20): begin
        w.term = TERM_ADD_P;
      end
      STEP_W'(21): begin
        w.term = TERM_SUB_X; w.xsel = X_Z3;
      end
      STEP_W'(22): begin
        w.dst = DST_T;
      end
      STEP_W'(23): begin
        w.mul_en = 1'b1; w.mul_a = MA_T; w.gain = G_RCP;
      end
      STEP_W'(24): begin
        w.base = BASE_ZERO; w.term = TERM_ADD_P;
      end
      STEP_W'(25): begin
        w.flow = FLOW_WAIT_OUT; w.jmp = 1'b1; w.target = '0; w.dst = DST_UP;
      end
      default: begin
        w.jmp = 1'b1; w.target = '0;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/ladrc_seq.sv */
// ----------------------------------------------------------------------------
// ladrc_seq
// step counter over the microcode program with handshake waits and jumps
// ----------------------------------------------------------------------------
`include "linear_adrc_controller_macros.svh"

module ladrc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_free,
  output ladrc_pkg::ucw_t  cw,
  output logic             adv,
  output logic             in_ready,
  output logic             emit
);
  import ladrc_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  always_comb begin
    cw = ucode(step_r);
  end

  always_comb begin
    case (cw.flow)
      FLOW_RUN:      adv = 1'b1;
      FLOW_WAIT_IN:  adv = in_valid;
      FLOW_WAIT_OUT: adv = out_free;
      default:       adv = 1'b1;
    endcase
  end

  assign in_ready = (cw.flow == FLOW_WAIT_IN);
  assign emit     = (cw.flow == FLOW_WAIT_OUT) && out_free;

  always_comb begin
    step_nxt = step_r;
    if (adv) begin
      step_nxt = cw.jmp ? cw.target : step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  `LADRC_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, step_r == STEP_W'(1))
  `LADRC_ASSERT_NXT(a_emit_wraps, clk, rst_n, emit, step_r == '0)
  `LADRC_ASSERT_NXT(a_stall_holds, clk, rst_n, cw.flow == FLOW_WAIT_OUT && !out_free, $stable(step_r))
  `LADRC_ASSERT_IMP(a_step_range, clk, rst_n, 1'b1, step_r < STEP_W'(NUM_STEPS))

endmodule

/* src/ladrc_dp.sv */
// ----------------------------------------------------------------------------
// ladrc_dp
// observer and control datapath: one multiplier, one accumulator, saturation
// ----------------------------------------------------------------------------
module ladrc_dp #(
  parameter int STEP_SHIFT = ladrc_pkg::STEP_SHIFT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ladrc_pkg::ucw_t                        cw,
  input  logic                                   adv,
  input  logic                                   y_load,
  input  logic signed [ladrc_pkg::DATA_W-1:0]    y_in,
  input  ladrc_pkg::cfg_t                        cfg,
  output ladrc_pkg::res_t                        res
);
  import ladrc_pkg::*;

  logic signed [DATA_W-1:0]      y_r, e0_r, t_r, z1_r, z2_r, z3_r, up_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          clip_r;

  logic signed [DATA_W-1:0]      x_val, mul_a_val, sat_val;
  logic [DATA_W-1:0]             gain_val;
  logic signed [PROD_FULL_W-1:0] prod_full;
  logic signed [ACC_W-1:0]       x_ext, prod_ext, tsh, base_val, term_val, acc_nxt;
  logic [ACC_W-DATA_W:0]         acc_hi;
  logic                          sat_clip;

  always_comb begin
    case (cw.xsel)
      X_Z1:    x_val = z1_r;
      X_Z2:    x_val = z2_r;
      X_Z3:    x_val = z3_r;
      X_Y:     x_val = y_r;
      X_SP:    x_val = cfg.setpoint;
      default: x_val = z1_r;
    endcase
  end

  always_comb begin
    case (cw.gain)
      G_B0:    gain_val = cfg.b0;
      G_RCP:   gain_val = cfg.rcp;
      G_B1:    gain_val = cfg.b1;
      G_B2:    gain_val = cfg.b2;
      G_B3:    gain_val = cfg.b3;
      G_KP:    gain_val = cfg.kp;
      G_KD:    gain_val = cfg.kd;
      default: gain_val = cfg.b0;
    endcase
  end

  always_comb begin
    case (cw.mul_a)
      MA_E0:   mul_a_val = e0_r;
      MA_UP:   mul_a_val = up_r;
      MA_T:    mul_a_val = t_r;
      default: mul_a_val = e0_r;
    endcase
  end

  // signed value times unsigned gain, floor of the q20 scaling
  assign prod_full = PROD_FULL_W'(mul_a_val) * PROD_FULL_W'($signed({1'b0, gain_val}));

  assign x_ext    = ACC_W'(x_val);
  assign prod_ext = ACC_W'(prod_r);
  assign tsh      = ACC_W'(t_r >>> STEP_SHIFT);

  always_comb begin
    case (cw.base)
      BASE_ACC:  base_val = acc_r;
      BASE_X:    base_val = x_ext;
      BASE_ZERO: base_val = '0;
      default:   base_val = acc_r;
    endcase
  end

  always_comb begin
    case (cw.term)
      TERM_NONE:    term_val = '0;
      TERM_ADD_P:   term_val = prod_ext;
      TERM_SUB_P:   term_val = -prod_ext;
      TERM_SUB_X:   term_val = -x_ext;
      TERM_ADD_TSH: term_val = tsh;
      default:      term_val = '0;
    endcase
  end

  assign acc_nxt = base_val + term_val;

  // saturate the accumulator to 32 bits
  assign acc_hi   = acc_r[ACC_W-1:DATA_W-1];
  assign sat_clip = !((&acc_hi) || !(|acc_hi));

  always_comb begin
    if (!sat_clip) begin
      sat_val = acc_r[DATA_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (y_load) begin
      y_r <= y_in;
    end
    if (adv) begin
      acc_r <= acc_nxt;
      if (cw.mul_en) begin
        prod_r <= prod_full[PROD_FULL_W-1:FRAC_BITS];
      end
      if (cw.dst == DST_E0) begin
        e0_r <= sat_val;
      end
      if (cw.dst == DST_T) begin
        t_r <= sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r   <= '0;
      z2_r   <= '0;
      z3_r   <= '0;
      up_r   <= '0;
      clip_r <= 1'b0;
    end else if (adv) begin
      case (cw.dst)
        DST_Z1:  z1_r <= sat_val;
        DST_Z2:  z2_r <= sat_val;
        DST_Z3:  z3_r <= sat_val;
        DST_UP:  up_r <= sat_val;
        default: ;
      endcase
      if (cw.clr) begin
        clip_r <= 1'b0;
      end else if (cw.dst != DST_NONE && sat_clip) begin
        clip_r <= 1'b1;
      end
    end
  end

  assign res.drive   = sat_val;
  assign res.disturb = z3_r;
  assign res.sat     = clip_r || (cw.dst != DST_NONE && sat_clip);

endmodule

/* src/linear_adrc_controller.sv */
// ----------------------------------------------------------------------------
// linear_adrc_controller
// linear adrc with a third-order extended state observer, microcoded
// ----------------------------------------------------------------------------
// usage
//   in_*  : one measured plant output per control tick, valid/ready beat
//   out_* : drive, disturbance estimate and clip flag, valid/ready beat
//   cfg_* : register writes (index, data), always ready; write while idle
// timing
//   a beat is accepted at program step 0; the program has 26 steps that
//   use one shared 32x33 multiplier and one 48-bit accumulator, and the
//   result is registered on out_* when the last step emits it
//   the next input beat is taken as soon as the sequencer returns to step 0,
//   and not before, while the last result may still wait
//   if the receiver stalls, the sequencer holds at its last step until the
//   output register is free, and no further input is taken
// reset
//   synchronous, active low: estimates and previous drive clear to zero,
//   registers take their default setpoint and gains, the sequencer returns to step 0
// ----------------------------------------------------------------------------
module linear_adrc_controller #(
  parameter int STEP_SHIFT = ladrc_pkg::STEP_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ladrc_pkg::DATA_W-1:0] in_measured_output,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ladrc_pkg::DATA_W-1:0] out_drive,
  output logic signed [ladrc_pkg::DATA_W-1:0] out_disturbance_estimate,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ladrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ladrc_pkg::DATA_W-1:0]        cfg_data
);
  import ladrc_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  res_t  res;
  res_t  out_r;
  logic  out_valid_r, out_valid_nxt;
  ucw_t  cw;
  logic  adv, emit, out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT:           cfg_nxt.setpoint = cfg_data;
        REG_CONTROL_GAIN:       cfg_nxt.b0       = cfg_data;
        REG_CONTROL_GAIN_RECIP: cfg_nxt.rcp      = cfg_data;
        REG_OBS_GAIN_ONE:       cfg_nxt.b1       = cfg_data;
        REG_OBS_GAIN_TWO:       cfg_nxt.b2       = cfg_data;
        REG_OBS_GAIN_THREE:     cfg_nxt.b3       = cfg_data;
        REG_PROP_GAIN:          cfg_nxt.kp       = cfg_data;
        REG_DERIV_GAIN:         cfg_nxt.kd       = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{setpoint: RST_SETPOINT, b0: RST_B0, rcp: RST_RCP, b1: RST_B1,
                       b2: RST_B2, b3: RST_B3, kp: RST_KP, kd: RST_KD};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  ladrc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .cw       (cw),
    .adv      (adv),
    .in_ready (in_ready),
    .emit     (emit)
  );

  ladrc_dp #(
    .STEP_SHIFT (STEP_SHIFT)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cw     (cw),
    .adv    (adv),
    .y_load (in_valid && in_ready),
    .y_in   (in_measured_output),
    .cfg    (cfg_r),
    .res    (res)
  );

  assign out_valid                = out_valid_r;
  assign out_drive                = out_r.drive;
  assign out_disturbance_estimate = out_r.disturb;
  assign out_saturated            = out_r.sat;

endmodule
